[rtl/core/wsd_pkg.sv]
// Shared types and constants for the WAV stream sample decoder.
// Holds the parse phase type, chunk tags, error codes and sample modes.
// No dependencies.
`default_nettype none

package wsd_pkg;

  typedef enum logic [3:0] {
    PH_RIFF    = 4'd0,
    PH_RSIZE   = 4'd1,
    PH_WAVE    = 4'd2,
    PH_CID     = 4'd3,
    PH_SZ_FMT  = 4'd4,
    PH_SZ_DATA = 4'd5,
    PH_SZ_SKIP = 4'd6,
    PH_FMT     = 4'd7,
    PH_SKIP    = 4'd8,
    PH_PAD     = 4'd9,
    PH_DATA    = 4'd10,
    PH_HALT    = 4'd11
  } phase_t;

  typedef enum logic [1:0] {
    SMP_PCM16 = 2'd0,
    SMP_PCM24 = 2'd1,
    SMP_FLT32 = 2'd2
  } smp_mode_t;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [2:0] ERR_BAD_RIFF    = 3'd0;
  localparam logic [2:0] ERR_BAD_WAVE    = 3'd1;
  localparam logic [2:0] ERR_CHANNELS    = 3'd2;
  localparam logic [2:0] ERR_FORMAT      = 3'd3;
  localparam logic [2:0] ERR_DATA_NO_FMT = 3'd4;

  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam logic [15:0] FMT_FLOAT = 16'd3;

  localparam logic [23:0] Q23_MAX = 24'h7F_FFFF;
  localparam logic [23:0] Q23_MIN = 24'h80_0000;

  localparam logic       KIND_FRAME = 1'b0;
  localparam logic       KIND_ERROR = 1'b1;

endpackage

`default_nettype wire

[rtl/core/wsd_sample_conv.sv]
// Sample converter: one little-endian sample word to signed Q1.23.
// Handles PCM16, PCM24 and float32 (truncating, saturating). Uses wsd_pkg.
`default_nettype none

module wsd_sample_conv (
  input  wire logic [31:0]       word,
  input  wire wsd_pkg::smp_mode_t mode,
  output logic      [23:0]       q23
);

  logic        neg;
  logic [7:0]  expo;
  logic [22:0] mant;
  logic [7:0]  shamt;
  logic [23:0] mag;
  logic [23:0] flt_q;

  assign neg   = word[31];
  assign expo  = word[30:23];
  assign mant  = word[22:0];
  assign shamt = 8'd127 - expo;
  assign mag   = {1'b1, mant} >> shamt[4:0];

  always_comb begin
    if (expo == 8'hFF) begin
      // NaN drops to zero, infinities saturate
      flt_q = (mant != 23'd0) ? 24'd0 : (neg ? wsd_pkg::Q23_MIN : wsd_pkg::Q23_MAX);
    end else if (expo == 8'd0) begin
      flt_q = 24'd0;
    end else if (expo >= 8'd127) begin
      flt_q = neg ? wsd_pkg::Q23_MIN : wsd_pkg::Q23_MAX;
    end else if (shamt >= 8'd24) begin
      flt_q = 24'd0;
    end else begin
      flt_q = neg ? (24'd0 - mag) : mag;
    end
  end

  always_comb begin
    case (mode)
      wsd_pkg::SMP_PCM16: q23 = {word[15:0], 8'h00};
      wsd_pkg::SMP_PCM24: q23 = word[23:0];
      wsd_pkg::SMP_FLT32: q23 = flt_q;
      default:            q23 = 24'd0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/wav_stream_sample_decoder.sv]
// WAV stream sample decoder top level: RIFF/WAVE byte parser and frame output.
// Depends on wsd_pkg and wsd_sample_conv.
//
//  channel | dir | tdata                         | tuser           | tlast
//  in_     | in  | [7:0] data_byte               | start_of_file   | -
//  out_    | out | [23:0] left, [47:24] right,   | result_kind     | last_frame
//          |     | [79:48] rate, [82:80] error   |                 |
//
// One byte per cycle sustained unless the output stalls. Each byte waits
// in the input register; its result, if any, enters the output register
// as the byte advances. The input register refills while the output register
// drains, so a stalled result only blocks input once both registers are full.
// Reset (rst_n low, synchronous) empties both registers and returns the parser
// to the RIFF tag; a beat with start_of_file set restarts the parse likewise.
`default_nettype none

module wav_stream_sample_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] start_of_file
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [87:0] out_tdata,  // [23:0] left, [47:24] right, [79:48] rate,
                                       // [82:80] error_code, [87:83] zero
  output logic             out_tuser,  // [0] result_kind
  output logic             out_tlast   // last_frame
);

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_sof_r;
  logic       advance;

  // parser state
  wsd_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]  fbc_r, fbc_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] cbl_r, cbl_nxt;
  logic [15:0] fmt_r, fmt_nxt;
  logic [15:0] chn_r, chn_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic        seen_r, seen_nxt;
  logic [63:0] asm_r, asm_nxt;
  logic [3:0]  fidx_r, fidx_nxt;
  logic [4:0]  fpos_r, fpos_nxt;
  logic        odd_r, odd_nxt;

  // current view after a possible restart
  wsd_pkg::phase_t c_phase;
  logic [1:0]  c_fbc;
  logic [31:0] c_tag;
  logic [31:0] c_cbl;
  logic [15:0] c_fmt;
  logic [15:0] c_chn;
  logic [31:0] c_rate;
  logic [15:0] c_bits;
  logic        c_seen;
  logic [63:0] c_asm;
  logic [3:0]  c_fidx;
  logic [4:0]  c_fpos;
  logic        c_odd;

  logic [31:0] word;
  logic [3:0]  bps;
  logic [5:0]  fbytes;
  logic        fmt_ok;
  logic [63:0] asm_cat;
  logic [31:0] cbl_dec;
  logic [31:0] left_word, right_word;
  logic [23:0] left_q, right_q;
  wsd_pkg::smp_mode_t mode;

  // result
  logic        emit;
  logic        res_kind;
  logic        res_last;
  logic [2:0]  res_err;
  logic [23:0] res_left, res_right;

  // output register
  logic        out_valid_r;
  logic        out_kind_r;
  logic        out_last_r;
  logic [2:0]  out_err_r;
  logic [23:0] out_left_r, out_right_r;
  logic [31:0] out_rate_r;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_sof_r  <= in_tuser;
    end
  end

  // restart view
  always_comb begin
    if (in_sof_r) begin
      c_phase = wsd_pkg::PH_RIFF;
      c_fbc   = 2'd0;
      c_tag   = 32'd0;
      c_cbl   = 32'd0;
      c_fmt   = 16'd0;
      c_chn   = 16'd0;
      c_rate  = 32'd0;
      c_bits  = 16'd0;
      c_seen  = 1'b0;
      c_asm   = 64'd0;
      c_fidx  = 4'd0;
      c_fpos  = 5'd0;
      c_odd   = 1'b0;
    end else begin
      c_phase = phase_r;
      c_fbc   = fbc_r;
      c_tag   = tag_r;
      c_cbl   = cbl_r;
      c_fmt   = fmt_r;
      c_chn   = chn_r;
      c_rate  = rate_r;
      c_bits  = bits_r;
      c_seen  = seen_r;
      c_asm   = asm_r;
      c_fidx  = fidx_r;
      c_fpos  = fpos_r;
      c_odd   = odd_r;
    end
  end

  assign word    = {in_byte_r, c_tag[31:8]};
  assign bps     = c_bits[6:3];
  assign fbytes  = 6'(bps) * 6'(c_chn[1:0]);
  assign fmt_ok  = ((c_fmt == wsd_pkg::FMT_PCM) && (c_bits == 16'd16 || c_bits == 16'd24)) ||
                   ((c_fmt == wsd_pkg::FMT_FLOAT) && (c_bits == 16'd32));
  assign asm_cat = c_asm | (64'(in_byte_r) << {c_fidx[2:0], 3'b000});
  assign cbl_dec = c_cbl - 32'd1;

  always_comb begin
    if (c_fmt == wsd_pkg::FMT_FLOAT) begin
      mode = wsd_pkg::SMP_FLT32;
    end else if (c_bits == 16'd16) begin
      mode = wsd_pkg::SMP_PCM16;
    end else begin
      mode = wsd_pkg::SMP_PCM24;
    end
  end

  assign left_word = asm_cat[31:0];
  always_comb begin
    case (bps)
      4'd3:    right_word = asm_cat[55:24];
      4'd4:    right_word = asm_cat[63:32];
      default: right_word = asm_cat[47:16];
    endcase
  end

  wsd_sample_conv u_conv_left (
    .word (left_word),
    .mode (mode),
    .q23  (left_q)
  );

  wsd_sample_conv u_conv_right (
    .word (right_word),
    .mode (mode),
    .q23  (right_q)
  );

  always_comb begin
    phase_nxt = c_phase;
    fbc_nxt   = c_fbc;
    tag_nxt   = c_tag;
    cbl_nxt   = c_cbl;
    fmt_nxt   = c_fmt;
    chn_nxt   = c_chn;
    rate_nxt  = c_rate;
    bits_nxt  = c_bits;
    seen_nxt  = c_seen;
    asm_nxt   = c_asm;
    fidx_nxt  = c_fidx;
    fpos_nxt  = c_fpos;
    odd_nxt   = c_odd;
    emit      = 1'b0;
    res_kind  = wsd_pkg::KIND_FRAME;
    res_err   = wsd_pkg::ERR_BAD_RIFF;
    res_last  = 1'b0;
    res_left  = 24'd0;
    res_right = 24'd0;

    case (c_phase)
      wsd_pkg::PH_RIFF, wsd_pkg::PH_RSIZE, wsd_pkg::PH_WAVE, wsd_pkg::PH_CID,
      wsd_pkg::PH_SZ_FMT, wsd_pkg::PH_SZ_DATA, wsd_pkg::PH_SZ_SKIP: begin
        tag_nxt = word;
        fbc_nxt = c_fbc + 2'd1;
        if (c_fbc == 2'd3) begin
          case (c_phase)
            wsd_pkg::PH_RIFF: begin
              if (word != wsd_pkg::TAG_RIFF) begin
                emit    = 1'b1;
                res_err = wsd_pkg::ERR_BAD_RIFF;
              end else begin
                phase_nxt = wsd_pkg::PH_RSIZE;
              end
            end
            wsd_pkg::PH_RSIZE: phase_nxt = wsd_pkg::PH_WAVE;
            wsd_pkg::PH_WAVE: begin
              if (word != wsd_pkg::TAG_WAVE) begin
                emit    = 1'b1;
                res_err = wsd_pkg::ERR_BAD_WAVE;
              end else begin
                phase_nxt = wsd_pkg::PH_CID;
              end
            end
            wsd_pkg::PH_CID: begin
              if (word == wsd_pkg::TAG_FMT) begin
                phase_nxt = wsd_pkg::PH_SZ_FMT;
              end else if (word == wsd_pkg::TAG_DATA) begin
                phase_nxt = wsd_pkg::PH_SZ_DATA;
              end else begin
                phase_nxt = wsd_pkg::PH_SZ_SKIP;
              end
            end
            wsd_pkg::PH_SZ_DATA: begin
              // first failing check wins
              if (!c_seen) begin
                emit    = 1'b1;
                res_err = wsd_pkg::ERR_DATA_NO_FMT;
              end else if (c_chn < 16'd1 || c_chn > 16'd2) begin
                emit    = 1'b1;
                res_err = wsd_pkg::ERR_CHANNELS;
              end else if (!fmt_ok) begin
                emit    = 1'b1;
                res_err = wsd_pkg::ERR_FORMAT;
              end else begin
                cbl_nxt   = word;
                asm_nxt   = 64'd0;
                fidx_nxt  = 4'd0;
                phase_nxt = (word < 32'(fbytes)) ? wsd_pkg::PH_HALT : wsd_pkg::PH_DATA;
              end
            end
            default: begin
              cbl_nxt = word;
              odd_nxt = word[0];
              if (c_phase == wsd_pkg::PH_SZ_FMT) begin
                fmt_nxt   = 16'd0;
                chn_nxt   = 16'd0;
                rate_nxt  = 32'd0;
                bits_nxt  = 16'd0;
                seen_nxt  = 1'b1;
                fpos_nxt  = 5'd0;
                phase_nxt = wsd_pkg::PH_FMT;
              end else begin
                phase_nxt = wsd_pkg::PH_SKIP;
              end
              // empty chunk: no body, no pad
              if (word == 32'd0) begin
                phase_nxt = wsd_pkg::PH_CID;
              end
            end
          endcase
          if (emit) begin
            res_kind  = wsd_pkg::KIND_ERROR;
            phase_nxt = wsd_pkg::PH_HALT;
          end
        end
      end

      wsd_pkg::PH_FMT: begin
        if (c_fpos < 5'd16) begin
          case (c_fpos)
            5'd0:  fmt_nxt[7:0]    = in_byte_r;
            5'd1:  fmt_nxt[15:8]   = in_byte_r;
            5'd2:  chn_nxt[7:0]    = in_byte_r;
            5'd3:  chn_nxt[15:8]   = in_byte_r;
            5'd4:  rate_nxt[7:0]   = in_byte_r;
            5'd5:  rate_nxt[15:8]  = in_byte_r;
            5'd6:  rate_nxt[23:16] = in_byte_r;
            5'd7:  rate_nxt[31:24] = in_byte_r;
            5'd14: bits_nxt[7:0]   = in_byte_r;
            5'd15: bits_nxt[15:8]  = in_byte_r;
            default: ;
          endcase
          fpos_nxt = c_fpos + 5'd1;
        end
        cbl_nxt = cbl_dec;
        if (cbl_dec == 32'd0) begin
          phase_nxt = c_odd ? wsd_pkg::PH_PAD : wsd_pkg::PH_CID;
        end
      end

      wsd_pkg::PH_SKIP: begin
        cbl_nxt = cbl_dec;
        if (cbl_dec == 32'd0) begin
          phase_nxt = c_odd ? wsd_pkg::PH_PAD : wsd_pkg::PH_CID;
        end
      end

      wsd_pkg::PH_PAD: begin
        odd_nxt   = 1'b0;
        phase_nxt = wsd_pkg::PH_CID;
      end

      wsd_pkg::PH_DATA: begin
        cbl_nxt  = cbl_dec;
        asm_nxt  = asm_cat;
        fidx_nxt = c_fidx + 4'd1;
        if (6'(c_fidx) + 6'd1 >= fbytes) begin
          emit      = 1'b1;
          res_kind  = wsd_pkg::KIND_FRAME;
          res_left  = left_q;
          res_right = (c_chn == 16'd2) ? right_q : left_q;
          res_last  = cbl_dec < 32'(fbytes);
          asm_nxt   = 64'd0;
          fidx_nxt  = 4'd0;
          if (res_last) begin
            phase_nxt = wsd_pkg::PH_HALT;
          end
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wsd_pkg::PH_RIFF;
      fbc_r   <= 2'd0;
      tag_r   <= 32'd0;
      cbl_r   <= 32'd0;
      fmt_r   <= 16'd0;
      chn_r   <= 16'd0;
      rate_r  <= 32'd0;
      bits_r  <= 16'd0;
      seen_r  <= 1'b0;
      asm_r   <= 64'd0;
      fidx_r  <= 4'd0;
      fpos_r  <= 5'd0;
      odd_r   <= 1'b0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      fbc_r   <= fbc_nxt;
      tag_r   <= tag_nxt;
      cbl_r   <= cbl_nxt;
      fmt_r   <= fmt_nxt;
      chn_r   <= chn_nxt;
      rate_r  <= rate_nxt;
      bits_r  <= bits_nxt;
      seen_r  <= seen_nxt;
      asm_r   <= asm_nxt;
      fidx_r  <= fidx_nxt;
      fpos_r  <= fpos_nxt;
      odd_r   <= odd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_kind_r  <= res_kind;
      out_last_r  <= res_last;
      out_err_r   <= (res_kind == wsd_pkg::KIND_ERROR) ? res_err : 3'd0;
      out_left_r  <= res_left;
      out_right_r <= res_right;
      out_rate_r  <= c_rate;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'd0, out_err_r, out_rate_r, out_right_r, out_left_r};

endmodule

`default_nettype wire

[rtl/core/wsd_checker.sv]
// Port-level checker for the WAV stream sample decoder, bound to the top level.
// Depends only on the top level's port list.
`default_nettype none

module wsd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [87:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        out_tlast
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  a_err_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[47:0] == 48'd0 && !out_tlast)
    else $error("error report carries samples or last flag");

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[82:80] <= 3'd4 && out_tdata[87:83] == 5'd0)
    else $error("error code out of range");

  a_frame_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[87:80] == 8'd0)
    else $error("frame carries an error code");

endmodule

bind wav_stream_sample_decoder wsd_checker u_wsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
